>>> rtl/dfe_pkg.sv
`default_nettype none

package dfe_pkg;

   // Longest frame, markers included.
   localparam int MAX_FRAME_BYTES = 256;
   // Position counter must be able to hold MAX_FRAME_BYTES itself.
   localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);

   // Result queue: one item yields up to two words.
   localparam int FIFO_DEPTH = 4;
   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   localparam int CSR_INDEX_W = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_START_LEN    = 3'd0,
      REG_START_FIRST  = 3'd1,
      REG_START_SECOND = 3'd2,
      REG_END_LEN      = 3'd3,
      REG_END_FIRST    = 3'd4,
      REG_END_SECOND   = 3'd5
   } csr_index_type;

   // Marker length code that selects two bytes; anything else means one.
   localparam logic [1:0] LEN_TWO = 2'd2;

   typedef struct packed {
      logic [1:0] start_len;
      logic [7:0] start_first;
      logic [7:0] start_second;
      logic [1:0] end_len;
      logic [7:0] end_first;
      logic [7:0] end_second;
   } cfg_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       frame_last;
      logic       frame_truncated;
   } result_type;

   // Words produced by one accepted item, oldest in res0.
   typedef struct packed {
      logic [1:0] count;
      result_type res0;
      result_type res1;
   } push_type;

endpackage

`default_nettype wire

>>> rtl/dfe_csr.sv
`default_nettype none

module dfe_csr
   import dfe_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [7:0]             csr_data,
   output cfg_type                     cfg
);

   cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_len    <= 2'd1;
         cfg_ff.start_first  <= 8'd0;
         cfg_ff.start_second <= 8'd0;
         cfg_ff.end_len      <= 2'd1;
         cfg_ff.end_first    <= 8'd10;
         cfg_ff.end_second   <= 8'd0;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            REG_START_LEN:    cfg_ff.start_len    <= csr_data[1:0];
            REG_START_FIRST:  cfg_ff.start_first  <= csr_data;
            REG_START_SECOND: cfg_ff.start_second <= csr_data;
            REG_END_LEN:      cfg_ff.end_len      <= csr_data[1:0];
            REG_END_FIRST:    cfg_ff.end_first    <= csr_data;
            REG_END_SECOND:   cfg_ff.end_second   <= csr_data;
            default: ;  // unmapped index: ignored
         endcase
      end
   end

endmodule

`default_nettype wire

>>> rtl/dfe_core.sv
`default_nettype none

module dfe_core
   import dfe_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic [7:0] rx_byte,
   input  wire cfg_type    cfg,
   output push_type        push
);

   logic             inside_ff, inside_in;
   logic             first_ff, first_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       prev_ff, prev_in;

   localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_FRAME_BYTES);

   always_comb begin
      logic             two_start;
      logic             two_end;
      logic [POS_W-1:0] end_len;
      logic             closes;

      two_start = (cfg.start_len == LEN_TWO);
      two_end   = (cfg.end_len == LEN_TWO);
      end_len   = two_end ? POS_W'(2) : POS_W'(1);
      closes    = 1'b0;

      inside_in = inside_ff;
      first_in  = first_ff;
      pos_in    = pos_ff;
      prev_in   = prev_ff;

      push.count = 2'd0;
      push.res0  = '{frame_byte: rx_byte, frame_last: 1'b0, frame_truncated: 1'b0};
      push.res1  = '{frame_byte: rx_byte, frame_last: 1'b0, frame_truncated: 1'b0};

      if (accept) begin
         if (!inside_ff) begin
            // hunting for the start marker
            if (two_start) begin
               if (!first_ff) begin
                  if (rx_byte == cfg.start_first) first_in = 1'b1;
               end else if (rx_byte == cfg.start_second) begin
                  inside_in  = 1'b1;
                  pos_in     = POS_W'(2);
                  prev_in    = rx_byte;
                  push.count = 2'd2;
                  push.res0.frame_byte = cfg.start_first;
               end else if (rx_byte != cfg.start_first) begin
                  first_in = 1'b0;
               end
            end else if (rx_byte == cfg.start_first) begin
               inside_in  = 1'b1;
               pos_in     = POS_W'(1);
               prev_in    = rx_byte;
               push.count = 2'd1;
            end
         end else if (pos_ff >= MAX_POS - end_len) begin
            // overflow: byte dropped, end marker sent in its place
            inside_in = 1'b0;
            first_in  = 1'b0;
            pos_in    = '0;
            if (two_end) begin
               push.count = 2'd2;
               push.res0.frame_byte = cfg.end_first;
               push.res1 = '{frame_byte: cfg.end_second, frame_last: 1'b1,
                             frame_truncated: 1'b1};
               prev_in = cfg.end_second;
            end else begin
               push.count = 2'd1;
               push.res0 = '{frame_byte: cfg.end_first, frame_last: 1'b1,
                             frame_truncated: 1'b1};
               prev_in = cfg.end_first;
            end
         end else begin
            if (two_end) begin
               closes = (prev_ff == cfg.end_first) && (rx_byte == cfg.end_second);
            end else begin
               closes = (rx_byte == cfg.end_first);
            end
            push.count = 2'd1;
            push.res0.frame_last = closes;
            prev_in = rx_byte;
            if (closes) begin
               inside_in = 1'b0;
               first_in  = 1'b0;
               pos_in    = '0;
            end else begin
               pos_in = pos_ff + POS_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff <= 1'b0;
         first_ff  <= 1'b0;
         pos_ff    <= '0;
         prev_ff   <= 8'd0;
      end else begin
         inside_ff <= inside_in;
         first_ff  <= first_in;
         pos_ff    <= pos_in;
         prev_ff   <= prev_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/dfe_fifo.sv
`default_nettype none

module dfe_fifo
   import dfe_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire push_type push,
   output logic      space_two,
   output logic      rsp_valid,
   input  wire logic rsp_ready,
   output result_type head
);

   result_type       mem [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && rsp_ready;
   assign space_two = (count_ff <= CNT_W'(FIFO_DEPTH - 2));
   assign head      = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in  = count_ff + CNT_W'(push.count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) mem[wr_ptr_ff] <= push.res0;
      if (push.count == 2'd2) mem[wr_ptr_ff + PTR_W'(1)] <= push.res1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/delimited_frame_extractor.sv
// channel   direction  ports                                  word
// req       in         req_valid/req_ready, req_rx_byte       one received byte
// rsp       out        rsp_valid/rsp_ready, rsp_frame_*       one frame byte + flags
// csr       in         csr_valid/csr_ready, csr_index/data    one register write
//
// One byte accepted per cycle while req_ready is high; its framing decision is
// made in the same cycle and its 0..2 output words land in a 4-entry result
// queue, whose registered head drives rsp. req_ready drops while the queue has
// fewer than two free entries, so req stalls once three words wait in the queue.
// csr_ready is always high; writes apply from the next byte on.
// Reset (synchronous, active high) clears framing state and queue, sets CSR defaults.
`default_nettype none

module delimited_frame_extractor
   import dfe_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,

   // byte input
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [7:0]             req_rx_byte,

   // frame output
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [7:0]                  rsp_frame_byte,
   output logic                        rsp_frame_last,
   output logic                        rsp_frame_truncated,

   // register writes
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [7:0]             csr_data
);

   cfg_type    cfg;
   push_type   push;
   result_type head;
   logic       space_two;
   logic       accept;

   // accept only when the queue can absorb the worst case of two words
   assign req_ready = space_two;
   assign accept    = req_valid && req_ready;

   dfe_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // marker hunt, end match and overflow handling
   dfe_core u_core (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_rx_byte),
      .cfg     (cfg),
      .push    (push)
   );

   // decouples the two-word bursts from the one-word output channel
   dfe_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space_two (space_two),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .head      (head)
   );

   assign rsp_frame_byte      = head.frame_byte;
   assign rsp_frame_last      = head.frame_last;
   assign rsp_frame_truncated = head.frame_truncated;

endmodule

`default_nettype wire

>>> rtl/dfe_checker.sv
`default_nettype none

module dfe_checker
   import dfe_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_frame_byte,
   input wire logic       rsp_frame_last,
   input wire logic       rsp_frame_truncated
);

   // a stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_frame_byte)
         && $stable(rsp_frame_last) && $stable(rsp_frame_truncated))
      else $error("rsp word changed while stalled");

   // nothing is left to send right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   // truncation flag only on a closing word
   a_trunc_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_truncated |-> rsp_frame_last)
      else $error("truncated word not marked last");

   // words only come from accepted bytes
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !(req_valid && req_ready) |=> !rsp_valid)
      else $error("rsp word without input");

endmodule

bind delimited_frame_extractor dfe_checker u_dfe_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_ready           (req_ready),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_frame_byte      (rsp_frame_byte),
   .rsp_frame_last      (rsp_frame_last),
   .rsp_frame_truncated (rsp_frame_truncated)
);

`default_nettype wire
